### hdl/ttem_pkg.sv
package ttem_pkg;

  // fixed port widths of the item fields
  localparam int CMD_W      = 2;
  localparam int PARTICLE_W = 10;
  localparam int EVENT_W    = 32;

  // command codes
  localparam logic [CMD_W-1:0] CMD_UPDATE  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_WRITE   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REBUILD = 2'd2;
  localparam logic [CMD_W-1:0] CMD_REPORT  = 2'd3;

  // verdict of the shared time comparator
  typedef struct packed {
    logic x_first;
    logic y_first;
  } cmp_res_t;

endpackage

### hdl/ttem_cmp.sv
module ttem_cmp #(
  parameter int TIME_BITS = 32
) (
  input  logic                 x_present,
  input  logic [TIME_BITS-1:0] x_time,
  input  logic                 y_present,
  input  logic [TIME_BITS-1:0] y_time,
  output ttem_pkg::cmp_res_t   res
);
  import ttem_pkg::*;

  logic x_lt;
  logic y_lt;

  // a missing event counts as infinitely late; ties favor neither side
  assign x_lt = x_time < y_time;
  assign y_lt = y_time < x_time;

  assign res.x_first = x_present && (!y_present || x_lt);
  assign res.y_first = y_present && (!x_present || y_lt);

endmodule

### hdl/tournament_tree_event_min.sv
// earliest-event finder over PARTICLES pending event times (winner tree)
// input channel: in_valid / in_stall carries one item: cmd, particle, event_at,
//   has_event. cmd update writes the time and replays the particle's path to
//   the root, write stores the time only, rebuild recomputes the whole tree,
//   report (code 3) only reads the root
// output channel: out_valid / out_stall carries one item per input item:
//   next_particle, next_time (zero when next_valid is low), next_valid
// one item is in work at a time; in_stall is high until its result is loaded
//   into the output register. write and report read the root index, then
//   its stored time; rebuild pairs the leaves, then the nodes bottom up.
//   the next item can be taken in the cycle after the result loads. each
//   tree level of an update is one time memory read for the sibling winner,
//   then the shared compare plus the tree read for the next level
// a stalled result stays in the output register; the block still accepts the
//   next item and waits before loading its result until the register frees
// reset: a clearing pass over all particles marks every particle as having
//   no event; in_stall is high meanwhile. the winner tree holds no defined
//   value until the first rebuild
module tournament_tree_event_min #(
  parameter int PARTICLES = 1024,
  parameter int TIME_BITS = 32
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [ttem_pkg::CMD_W-1:0]         cmd,
  input  logic [ttem_pkg::PARTICLE_W-1:0]    particle,
  input  logic [ttem_pkg::EVENT_W-1:0]       event_at,
  input  logic                               has_event,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [ttem_pkg::PARTICLE_W-1:0]    next_particle,
  output logic [ttem_pkg::EVENT_W-1:0]       next_time,
  output logic                               next_valid
);
  import ttem_pkg::*;

  localparam int IDX_W = $clog2(PARTICLES);
  localparam logic [IDX_W-1:0] LEAF_BASE = IDX_W'(PARTICLES / 2 - 1);
  localparam logic [IDX_W-1:0] LAST_PAIR = IDX_W'(PARTICLES - 2);
  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(PARTICLES - 1);
  localparam logic [IDX_W-1:0] IDX_ONE   = IDX_W'(1);
  localparam logic [IDX_W-1:0] IDX_TWO   = IDX_W'(2);

  // sequencer states
  localparam logic [3:0] ST_CLEAR      = 4'd0;
  localparam logic [3:0] ST_IDLE       = 4'd1;
  localparam logic [3:0] ST_U_LEAF     = 4'd2;
  localparam logic [3:0] ST_U_SIB      = 4'd3;
  localparam logic [3:0] ST_U_CMP      = 4'd4;
  localparam logic [3:0] ST_R_ROOT     = 4'd5;
  localparam logic [3:0] ST_R_DATA     = 4'd6;
  localparam logic [3:0] ST_B_LEAF_RD  = 4'd7;
  localparam logic [3:0] ST_B_LEAF_CMP = 4'd8;
  localparam logic [3:0] ST_B_NODE_RD  = 4'd9;
  localparam logic [3:0] ST_B_NODE_IDX = 4'd10;
  localparam logic [3:0] ST_B_NODE_CMP = 4'd11;
  localparam logic [3:0] ST_DONE       = 4'd12;

  logic [3:0]       state;
  logic [IDX_W-1:0] node;      // clear address, pair index or tree node

  // input field adaptation: index modulo PARTICLES, time kept to TIME_BITS
  logic [IDX_W+PARTICLE_W-1:0]   part_ext;
  logic [TIME_BITS+EVENT_W-1:0]  time_ext;
  logic [IDX_W-1:0]              a_in;
  logic [TIME_BITS-1:0]          t_in;
  logic                          accept;

  assign part_ext = {{IDX_W{1'b0}}, particle};
  assign time_ext = {{TIME_BITS{1'b0}}, event_at};
  assign a_in     = part_ext[IDX_W-1:0];
  assign t_in     = time_ext[TIME_BITS-1:0];
  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;

  // item being worked on
  logic [IDX_W-1:0]     cur_a;
  logic                 cur_has;
  logic [TIME_BITS-1:0] cur_time;

  // running winner and candidate particle indices
  logic [IDX_W-1:0]     w_idx;
  logic                 w_present;
  logic [TIME_BITS-1:0] w_time;
  logic [IDX_W-1:0]     xi;
  logic [IDX_W-1:0]     yi;

  // shared comparator and its operand selection
  logic [IDX_W-1:0]     x_idx;
  logic                 x_present;
  logic [TIME_BITS-1:0] x_time;
  logic [IDX_W-1:0]     y_idx;
  logic                 y_present;
  logic [TIME_BITS-1:0] y_time;
  cmp_res_t             res;
  logic [IDX_W-1:0]     win_idx;
  logic                 win_present;
  logic [TIME_BITS-1:0] win_time;

  // per-particle memory: {present, time}
  logic [TIME_BITS:0] pmem [PARTICLES];
  logic               pm_we;
  logic [IDX_W-1:0]   pm_wa;
  logic [TIME_BITS:0] pm_wd;
  logic [IDX_W-1:0]   pm_ra;
  logic [IDX_W-1:0]   pm_rb;
  logic [TIME_BITS:0] pa;
  logic [TIME_BITS:0] pb;

  // winner tree memory, heap layout with the root at node 0
  logic [IDX_W-1:0] tmem [PARTICLES-1];
  logic             tr_we;
  logic [IDX_W-1:0] tr_wa;
  logic [IDX_W-1:0] tr_ra;
  logic [IDX_W-1:0] tr_rb;
  logic [IDX_W-1:0] ta;
  logic [IDX_W-1:0] tb;

  always_ff @(posedge clk) begin
    if (pm_we) begin
      pmem[pm_wa] <= pm_wd;
    end
    pa <= pmem[pm_ra];
    pb <= pmem[pm_rb];
  end

  always_ff @(posedge clk) begin
    if (tr_we) begin
      tmem[tr_wa] <= win_idx;
    end
    ta <= tmem[tr_ra];
    tb <= tmem[tr_rb];
  end

  // tree address arithmetic
  logic [IDX_W-1:0] leaf_cur;
  logic [IDX_W-1:0] leaf_node;
  logic [IDX_W-1:0] sib_leaf;
  logic [IDX_W-1:0] par_node;
  logic [IDX_W-1:0] sib_par;

  assign leaf_cur  = (cur_a >> 1) + LEAF_BASE;
  assign leaf_node = (node >> 1) + LEAF_BASE;
  assign sib_leaf  = leaf_cur[0] ? leaf_cur + IDX_ONE : leaf_cur - IDX_ONE;
  assign par_node  = (node - IDX_ONE) >> 1;
  assign sib_par   = par_node[0] ? par_node + IDX_ONE : par_node - IDX_ONE;

  always_comb begin
    x_idx     = xi;
    x_present = pa[TIME_BITS];
    x_time    = pa[TIME_BITS-1:0];
    y_idx     = w_idx;
    y_present = w_present;
    y_time    = w_time;
    unique case (state)
      ST_U_LEAF: begin
        // the written particle against its partner
        x_idx     = cur_a;
        x_present = cur_has;
        x_time    = cur_time;
        y_idx     = cur_a ^ IDX_ONE;
        y_present = pa[TIME_BITS];
        y_time    = pa[TIME_BITS-1:0];
      end
      ST_B_LEAF_CMP: begin
        x_idx     = node;
        y_idx     = node | IDX_ONE;
        y_present = pb[TIME_BITS];
        y_time    = pb[TIME_BITS-1:0];
      end
      ST_B_NODE_CMP: begin
        y_idx     = yi;
        y_present = pb[TIME_BITS];
        y_time    = pb[TIME_BITS-1:0];
      end
      default: begin
      end
    endcase
  end

  ttem_cmp #(
    .TIME_BITS(TIME_BITS)
  ) u_cmp (
    .x_present(x_present),
    .x_time   (x_time),
    .y_present(y_present),
    .y_time   (y_time),
    .res      (res)
  );

  // x wins only when strictly earlier; a tie goes to y
  assign win_idx     = res.x_first ? x_idx : y_idx;
  assign win_present = res.x_first ? x_present : y_present;
  assign win_time    = res.x_first ? x_time : y_time;

  // memory port control
  always_comb begin
    pm_we = 1'b0;
    pm_wa = a_in;
    pm_wd = {has_event, t_in};
    pm_ra = a_in ^ IDX_ONE;
    pm_rb = node | IDX_ONE;
    tr_we = 1'b0;
    tr_wa = par_node;
    tr_ra = '0;
    tr_rb = node;
    unique case (state)
      ST_CLEAR: begin
        pm_we = 1'b1;
        pm_wa = node;
        pm_wd = '0;
      end
      ST_IDLE: begin
        pm_we = accept && (cmd == CMD_UPDATE || cmd == CMD_WRITE);
      end
      ST_U_LEAF: begin
        tr_we = 1'b1;
        tr_wa = leaf_cur;
        tr_ra = sib_leaf;
      end
      ST_U_SIB: begin
        pm_ra = ta;
      end
      ST_U_CMP: begin
        // write the parent and fetch its sibling for the next level
        tr_we = 1'b1;
        tr_wa = par_node;
        tr_ra = sib_par;
      end
      ST_R_ROOT: begin
        pm_ra = ta;
      end
      ST_B_LEAF_RD: begin
        pm_ra = node;
      end
      ST_B_LEAF_CMP: begin
        tr_we = 1'b1;
        tr_wa = leaf_node;
      end
      ST_B_NODE_RD: begin
        tr_ra = node - IDX_ONE;
      end
      ST_B_NODE_IDX: begin
        pm_ra = ta;
        pm_rb = tb;
      end
      ST_B_NODE_CMP: begin
        tr_we = 1'b1;
        tr_wa = par_node;
      end
      default: begin
      end
    endcase
  end

  logic out_free;
  assign out_free = !out_valid || !out_stall;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      node      <= '0;
      out_valid <= 1'b0;
    end else begin
      // a finished result loads as soon as the output register frees
      if (state == ST_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          node <= node + IDX_ONE;
          if (node == LAST_IDX) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            unique case (cmd)
              CMD_UPDATE:  state <= ST_U_LEAF;
              CMD_WRITE:   state <= ST_R_ROOT;
              CMD_REPORT:  state <= ST_R_ROOT;
              CMD_REBUILD: begin
                state <= ST_B_LEAF_RD;
                node  <= '0;
              end
            endcase
          end
        end
        ST_U_LEAF: begin
          node  <= leaf_cur;
          state <= ST_U_SIB;
        end
        ST_U_SIB: state <= ST_U_CMP;
        ST_U_CMP: begin
          node  <= par_node;
          state <= (par_node == '0) ? ST_DONE : ST_U_SIB;
        end
        ST_R_ROOT:    state <= ST_R_DATA;
        ST_R_DATA:    state <= ST_DONE;
        ST_B_LEAF_RD: state <= ST_B_LEAF_CMP;
        ST_B_LEAF_CMP: begin
          if (node == LAST_PAIR) begin
            state <= ST_B_NODE_RD;
          end else begin
            node  <= node + IDX_TWO;
            state <= ST_B_LEAF_RD;
          end
        end
        ST_B_NODE_RD:  state <= ST_B_NODE_IDX;
        ST_B_NODE_IDX: state <= ST_B_NODE_CMP;
        ST_B_NODE_CMP: begin
          if (node == IDX_TWO) begin
            state <= ST_DONE;
          end else begin
            node  <= node - IDX_TWO;
            state <= ST_B_NODE_RD;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // result fields at port width
  logic [IDX_W+PARTICLE_W-1:0] root_ext;
  logic [TIME_BITS+EVENT_W-1:0] wtime_ext;

  assign root_ext  = {{PARTICLE_W{1'b0}}, w_idx};
  assign wtime_ext = {{EVENT_W{1'b0}}, w_time};

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      cur_a    <= a_in;
      cur_has  <= has_event;
      cur_time <= t_in;
    end
    unique case (state)
      ST_U_LEAF, ST_U_CMP, ST_B_NODE_CMP: begin
        w_idx     <= win_idx;
        w_present <= win_present;
        w_time    <= win_time;
      end
      ST_U_SIB: xi <= ta;
      ST_R_ROOT: w_idx <= ta;
      ST_R_DATA: begin
        w_present <= pa[TIME_BITS];
        w_time    <= pa[TIME_BITS-1:0];
      end
      ST_B_NODE_IDX: begin
        xi <= ta;
        yi <= tb;
      end
      default: begin
      end
    endcase
    if (state == ST_DONE && out_free) begin
      next_particle <= root_ext[PARTICLE_W-1:0];
      next_time     <= w_present ? wtime_ext[EVENT_W-1:0] : '0;
      next_valid    <= w_present;
    end
  end

  // in the compare states the comparator never declares both sides first
  a_cmp_excl: assert property (@(posedge clk) disable iff (rst)
    (state == ST_U_LEAF || state == ST_U_CMP || state == ST_B_LEAF_CMP ||
     state == ST_B_NODE_CMP) |-> !(res.x_first && res.y_first))
    else $error("comparator picked both sides");

  // an accepted item keeps the block busy in the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> in_stall)
    else $error("block ready right after accepting an item");

  // tree writes stay inside the tree
  a_tree_range: assert property (@(posedge clk) disable iff (rst)
    tr_we |-> (tr_wa <= LAST_PAIR))
    else $error("tree write out of range");

  // a finished result waits while the output register is blocked
  a_done_wait: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && out_valid && out_stall) |=> (state == ST_DONE))
    else $error("result loaded over a stalled item");

endmodule

### bench/event_min_checker.sv
`timescale 1ns / 1ps

module event_min_checker #(
  parameter int PARTICLES = 1024
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  logic [ttem_pkg::CMD_W-1:0]      cmd,
  input  logic [ttem_pkg::PARTICLE_W-1:0] particle,
  input  logic [ttem_pkg::EVENT_W-1:0]    event_at,
  input  logic                            has_event,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  logic [ttem_pkg::PARTICLE_W-1:0] next_particle,
  input  logic [ttem_pkg::EVENT_W-1:0]    next_time,
  input  logic                            next_valid,
  output int                              failures,
  output int                              outstanding
);
  import ttem_pkg::*;

  typedef struct packed {
    logic [PARTICLE_W-1:0] particle;
    logic [EVENT_W-1:0]    at;
    logic                  valid;
  } root_report_t;

  logic [EVENT_W-1:0] due_time [PARTICLES];
  bit                 due_flag [PARTICLES];
  int unsigned        winners  [PARTICLES-1];
  root_report_t       expected_roots [$];

  // strict: a particle without an event is never sooner than another
  function automatic bit sooner(input int unsigned x, input int unsigned y);
    if (!due_flag[x]) return 1'b0;
    if (!due_flag[y]) return 1'b1;
    return due_time[x] < due_time[y];
  endfunction

  function automatic int unsigned leaf_node(input int unsigned a);
    return a / 2 + PARTICLES / 2 - 1;
  endfunction

  // leaf keeps the partner on a tie
  function automatic void seat_leaf(input int unsigned a);
    int unsigned partner;
    partner = a ^ 1;
    winners[leaf_node(a)] = sooner(a, partner) ? a : partner;
  endfunction

  // climbing side keeps a tie
  function automatic void replay_path(input int unsigned node);
    int unsigned parent, sib, s, c;
    while (node != 0 && node < PARTICLES - 1) begin
      parent = (node - 1) / 2;
      sib = (node % 2 == 1) ? node + 1 : node - 1;
      s = winners[sib];
      c = winners[node];
      winners[parent] = sooner(s, c) ? s : c;
      node = parent;
    end
  endfunction

  // right child wins a tie
  function automatic void rebuild_tree();
    int unsigned l, r;
    for (int i = 0; i < PARTICLES; i += 2) seat_leaf(i);
    for (int i = PARTICLES - 2; i > 0; i -= 2) begin
      l = winners[i-1];
      r = winners[i];
      winners[(i-1)/2] = sooner(l, r) ? l : r;
    end
  endfunction

  function automatic root_report_t apply_item(input logic [CMD_W-1:0] op,
                                              input logic [PARTICLE_W-1:0] p,
                                              input logic [EVENT_W-1:0] t,
                                              input logic h);
    root_report_t r;
    int unsigned a, head;
    a = p % PARTICLES;
    if (op == CMD_UPDATE || op == CMD_WRITE) begin
      due_time[a] = t;
      due_flag[a] = h;
      if (op == CMD_UPDATE) begin
        seat_leaf(a);
        replay_path(leaf_node(a));
      end
    end else if (op == CMD_REBUILD) begin
      rebuild_tree();
    end
    head = winners[0] % PARTICLES;
    r.particle = head[PARTICLE_W-1:0];
    r.valid = due_flag[head];
    r.at = due_flag[head] ? due_time[head] : '0;
    return r;
  endfunction

  always @(posedge clk) begin
    root_report_t want;
    int bad;
    bad = 0;
    if (rst) begin
      foreach (due_flag[i]) due_flag[i] = 1'b0;
      foreach (winners[i]) winners[i] = 0;
      expected_roots.delete();
      failures <= 0;
      outstanding <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_roots.size() == 0) begin
          $error("next_particle: no item pending, got %0d", next_particle);
          bad++;
        end else begin
          want = expected_roots.pop_front();
          if (next_particle !== want.particle) begin
            $error("next_particle: expected %0d, got %0d", want.particle, next_particle);
            bad++;
          end
          if (next_time !== want.at) begin
            $error("next_time: expected %h, got %h", want.at, next_time);
            bad++;
          end
          if (next_valid !== want.valid) begin
            $error("next_valid: expected %b, got %b", want.valid, next_valid);
            bad++;
          end
        end
      end
      if (in_valid && !in_stall)
        expected_roots.push_back(apply_item(cmd, particle, event_at, has_event));
      failures <= failures + bad;
      outstanding <= expected_roots.size();
    end
  end

endmodule

### bench/tournament_tree_event_min_test.sv
`timescale 1ns / 1ps

module tournament_tree_event_min_test;
  import ttem_pkg::*;

  // no handshake for this long means the block is stuck; the slowest
  // correct gap is a rebuild or the long hold
  localparam int LIMIT        = 20000;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 50;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 200;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  logic [CMD_W-1:0]      cmd       = CMD_REPORT;
  logic [PARTICLE_W-1:0] particle  = '0;
  logic [EVENT_W-1:0]    event_at  = '0;
  logic                  has_event = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [PARTICLE_W-1:0] next_particle;
  logic [EVENT_W-1:0]    next_time;
  logic                  next_valid;

  int failures;
  int outstanding;
  int quiet_cycles = 0;

  // steady: neither side idles; hold_off: receiver takes one long break
  bit steady   = 1'b0;
  bit hold_off = 1'b0;

  tournament_tree_event_min dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .cmd           (cmd),
    .particle      (particle),
    .event_at      (event_at),
    .has_event     (has_event),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .next_particle (next_particle),
    .next_time     (next_time),
    .next_valid    (next_valid)
  );

  // tracks stored times and the winner tree, compares every root report
  event_min_checker root_check (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .cmd           (cmd),
    .particle      (particle),
    .event_at      (event_at),
    .has_event     (has_event),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .next_particle (next_particle),
    .next_time     (next_time),
    .next_valid    (next_valid),
    .failures      (failures),
    .outstanding   (outstanding)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // watchdog: counts cycles in which neither channel moves an item
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic int idle_draw();
    return steady ? 0 : $urandom_range(0, 14);
  endfunction

  // idle for a drawn number of cycles, then offer one item until taken;
  // valid stays high on return so back-to-back items need no dip
  task automatic offer(input logic [CMD_W-1:0] c, input logic [PARTICLE_W-1:0] p,
                       input logic [EVENT_W-1:0] t, input logic h);
    int gap;
    gap = idle_draw();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    cmd       <= c;
    particle  <= p;
    event_at  <= t;
    has_event <= h;
    do @(posedge clk); while (in_stall);
  endtask

  // sender pause: nothing offered until every root report is back
  task automatic wait_all_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // mostly path replays; a few write-only, report and rebuild items.
  // a small hot set of particles and narrow time ranges make ties common
  task automatic random_item();
    logic [CMD_W-1:0]      c;
    logic [PARTICLE_W-1:0] p;
    logic [EVENT_W-1:0]    t;
    logic                  h;
    int                    roll;
    roll = $urandom_range(0, 99);
    if (roll < 2) c = CMD_REBUILD;
    else if (roll < 10) c = CMD_WRITE;
    else if (roll < 16) c = CMD_REPORT;
    else c = CMD_UPDATE;
    if ($urandom_range(0, 3) == 0) p = PARTICLE_W'($urandom_range(0, 15));
    else p = PARTICLE_W'($urandom_range(0, 1023));
    roll = $urandom_range(0, 9);
    if (roll < 2) t = $urandom_range(0, 3);
    else if (roll == 2) t = 32'hFFFF_FFFF - $urandom_range(0, 3);
    else t = $urandom;
    h = ($urandom_range(0, 7) != 0);
    offer(c, p, t, h);
  endtask

  // receiver: stalls a drawn number of cycles before each item, once a long
  // hold so the block fills up and stalls its input
  initial begin
    int n;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_off) begin
        n = HOLD_CYCLES;
        hold_off = 1'b0;
      end else begin
        n = idle_draw();
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // sender and verdict
  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // tree must be built before any root read, so a rebuild comes first
    offer(CMD_REBUILD, 10'd0, 32'h0, 1'b0);
    offer(CMD_UPDATE, 10'd0, 32'h0, 1'b1);
    // leaf tie: the partner stays
    offer(CMD_UPDATE, 10'd1, 32'h0, 1'b1);
    // internal tie: the climbing side stays
    offer(CMD_UPDATE, 10'd2, 32'h0, 1'b1);
    offer(CMD_UPDATE, 10'd1023, 32'hFFFF_FFFF, 1'b1);
    // partner with no event at the top end
    offer(CMD_UPDATE, 10'd1022, 32'hFFFF_FFFF, 1'b0);
    offer(CMD_UPDATE, 10'd512, 32'h0001_0000, 1'b1);
    // write only: the tree goes stale; the report reads the root particle's stored time
    offer(CMD_WRITE, 10'd0, 32'hFFFF_FFFF, 1'b1);
    offer(CMD_REPORT, 10'd1023, 32'hFFFF_FFFF, 1'b1);
    offer(CMD_UPDATE, 10'd0, 32'hFFFF_FFFE, 1'b1);
    offer(CMD_REBUILD, 10'd3, 32'h1234_5678, 1'b1);
    // clear every event: root falls back to a particle with none
    offer(CMD_UPDATE, 10'd1, 32'h0, 1'b0);
    offer(CMD_UPDATE, 10'd2, 32'h0, 1'b0);
    offer(CMD_UPDATE, 10'd512, 32'h0001_0000, 1'b0);
    offer(CMD_UPDATE, 10'd0, 32'hFFFF_FFFE, 1'b0);
    offer(CMD_UPDATE, 10'd1023, 32'hFFFF_FFFF, 1'b0);
    offer(CMD_REPORT, 10'd0, 32'h0, 1'b0);
    // equal times written without sorting, then a rebuild: right child wins
    offer(CMD_WRITE, 10'd4, 32'h7, 1'b1);
    offer(CMD_WRITE, 10'd6, 32'h7, 1'b1);
    offer(CMD_REBUILD, 10'd0, 32'h0, 1'b0);
    // alternating bit patterns on particle and time
    offer(CMD_UPDATE, 10'd682, 32'hAAAA_AAAA, 1'b1);
    offer(CMD_UPDATE, 10'd341, 32'h5555_5555, 1'b1);
    offer(CMD_UPDATE, 10'd4, 32'hFFFF_FFFF, 1'b1);
    offer(CMD_REPORT, 10'd1023, 32'hFFFF_FFFF, 1'b0);
    wait_all_results();

    // random phases: some without idling, one with the long receiver hold,
    // pauses for a full drain after every other phase
    for (int ph = 0; ph < PHASES; ph++) begin
      steady = (ph % 3 == 1);
      if (ph == 2) hold_off = 1'b1;
      for (int k = 0; k < PHASE_ITEMS; k++) random_item();
      if (ph % 2 == 1) wait_all_results();
    end

    wait_all_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

### files.f
hdl/ttem_pkg.sv
hdl/ttem_cmp.sv
hdl/tournament_tree_event_min.sv
bench/event_min_checker.sv
bench/tournament_tree_event_min_test.sv
